// ===== hdl/mlt_pkg.sv =====
// Shared types and constants for the MAC learning table.
package mlt_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_PORT_COUNT    = 16;

    localparam int MAC_W   = 48;
    localparam int PORT_W  = 4;
    localparam int STAMP_W = 32;
    localparam int AGE_W   = 16;
    localparam int AGED_W  = 7;

    localparam logic [AGED_W-1:0] AGED_MAX      = 7'd127;
    localparam logic [AGE_W-1:0]  MAX_AGE_RESET = 16'd300;
    localparam logic              REG_MAX_AGE   = 1'b0;

    typedef enum logic [1:0] {
        CMD_LEARN  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_AGE    = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [MAC_W-1:0]   mac;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] now;
        logic [AGE_W-1:0]   max_age;
    } t_bcast;

    typedef struct packed {
        logic              active;
        logic              found;
        logic [PORT_W-1:0] fport;
        logic              free_ok;
        logic [AGED_W-1:0] aged;
    } t_link;

endpackage

// ===== hdl/mlt_cell.sv =====
// One table entry cell; works on the command token as it passes and hands it on.
module mlt_cell
    import mlt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bcast i_bc,
    input  logic   i_wr_en,
    input  t_link  i_link,
    output t_link  o_link
);

    logic               r_valid;
    logic [MAC_W-1:0]   r_mac;
    logic [PORT_W-1:0]  r_port;
    logic [STAMP_W-1:0] r_stamp;
    logic               r_pick;
    t_link              r_link;
    t_link              n_link;

    logic w_match;
    logic w_old;
    logic w_sel;
    logic w_claim;
    logic [STAMP_W-1:0] w_age;

    assign w_match = r_valid && (r_mac == i_bc.mac);
    assign w_age   = i_bc.now - r_stamp;
    assign w_old   = r_valid && (w_age > {{(STAMP_W-AGE_W){1'b0}}, i_bc.max_age});
    assign w_claim = (i_bc.cmd == CMD_LEARN) && !r_valid && !i_link.free_ok;
    assign w_sel   = i_wr_en && r_pick;

    always_comb begin
        n_link = i_link;
        unique case (i_bc.cmd)
            CMD_LEARN: begin
                if (w_match) begin
                    n_link.found = 1'b1;
                end else if (w_claim) begin
                    n_link.free_ok = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (w_match && !i_link.found) begin
                    n_link.found = 1'b1;
                    n_link.fport = r_port;
                end
            end
            CMD_AGE: begin
                if (w_old && (i_link.aged != AGED_MAX)) begin
                    n_link.aged = i_link.aged + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_link.found   <= n_link.found;
        r_link.fport   <= n_link.fport;
        r_link.free_ok <= n_link.free_ok;
        r_link.aged    <= n_link.aged;
        if (w_sel) begin
            r_mac   <= i_bc.mac;
            r_port  <= i_bc.port;
            r_stamp <= i_bc.now;
        end else if (i_link.active && (i_bc.cmd == CMD_LEARN) && w_match) begin
            r_port  <= i_bc.port;
            r_stamp <= i_bc.now;
        end
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_link.active <= 1'b0;
        end else begin
            r_link.active <= i_link.active;
            if (i_link.active) begin
                r_pick <= w_claim;
            end
            if (w_sel) begin
                r_valid <= 1'b1;
            end else if (i_link.active && (i_bc.cmd == CMD_AGE) && w_old) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_link = r_link;

endmodule

// ===== hdl/mac_learning_table_with_aging_core.sv =====
// Top level of the MAC learning table: command control, registers and the cell chain.
// A command is taken when start is high and busy is low. Tick, and a learn whose port is
// out of range, finish at once: the result strobes on o_done in the next cycle. Learn,
// lookup and age send a token down the chain of TABLE_ENTRIES entry cells, one cell per
// clock; busy stays high until the cycle the result is shown. o_done is high for one
// cycle per result, while the result outputs hold until the next result; the receiver
// cannot stall it. Entry valid bits clear at reset; no clearing pass is needed.
module mac_learning_table_with_aging_core
    import mlt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int PORT_COUNT    = DEF_PORT_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [MAC_W-1:0]  i_mac_address,
    input  logic [PORT_W-1:0] i_port_number,
    output logic              o_done,
    output logic              o_hit,
    output logic [PORT_W-1:0] o_found_port,
    output logic [AGED_W-1:0] o_aged_count,
    output logic              o_learn_dropped,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic               r_busy;
    logic               r_launch;
    logic               r_done;
    logic [STAMP_W-1:0] r_now;
    logic [AGE_W-1:0]   r_max_age;
    t_cmd               r_cmd;
    logic [MAC_W-1:0]   r_mac;
    logic [PORT_W-1:0]  r_port;
    logic               r_hit;
    logic [PORT_W-1:0]  r_found_port;
    logic [AGED_W-1:0]  r_aged;
    logic               r_dropped;

    t_cmd   w_cmd;
    logic   w_acc;
    logic   w_quick;
    logic   w_cfg_wr;
    t_bcast w_bc;
    logic   w_wr_en;
    t_link  w_link [0:TABLE_ENTRIES];
    t_link  w_last;

    assign w_cmd    = t_cmd'(i_command);
    assign w_acc    = start && !r_busy;
    assign w_quick  = (w_cmd == CMD_TICK) ||
                      ((w_cmd == CMD_LEARN) && (32'(i_port_number) >= PORT_COUNT));
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_AGE) &&
                      (pwdata[AGE_W-1:0] != '0);

    assign w_bc.cmd     = r_cmd;
    assign w_bc.mac     = r_mac;
    assign w_bc.port    = r_port;
    assign w_bc.now     = r_now;
    assign w_bc.max_age = r_max_age;

    always_comb begin
        w_link[0]        = '0;
        w_link[0].active = r_launch;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            mlt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bc    (w_bc),
                .i_wr_en (w_wr_en),
                .i_link  (w_link[gi]),
                .o_link  (w_link[gi+1])
            );
        end
    endgenerate

    assign w_last  = w_link[TABLE_ENTRIES];
    assign w_wr_en = w_last.active && (r_cmd == CMD_LEARN) && !w_last.found &&
                     w_last.free_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_launch  <= 1'b0;
            r_done    <= 1'b0;
            r_now     <= '0;
            r_max_age <= MAX_AGE_RESET;
        end else begin
            r_launch <= w_acc && !w_quick;
            r_done   <= (w_acc && w_quick) || w_last.active;
            if (w_cfg_wr) begin
                r_max_age <= pwdata[AGE_W-1:0];
            end
            if (w_acc && (w_cmd == CMD_TICK)) begin
                r_now <= r_now + 1'b1;
            end
            if (w_acc && !w_quick) begin
                r_busy <= 1'b1;
            end else if (w_last.active) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd  <= w_cmd;
            r_mac  <= i_mac_address;
            r_port <= i_port_number;
            if (w_quick) begin
                r_hit        <= 1'b0;
                r_found_port <= '0;
                r_aged       <= '0;
                r_dropped    <= 1'b0;
            end
        end
        if (w_last.active) begin
            r_hit        <= (r_cmd == CMD_LOOKUP) && w_last.found;
            r_found_port <= ((r_cmd == CMD_LOOKUP) && w_last.found) ? w_last.fport : '0;
            r_aged       <= (r_cmd == CMD_AGE) ? w_last.aged : '0;
            r_dropped    <= (r_cmd == CMD_LEARN) && !w_last.found && !w_last.free_ok;
        end
    end

    assign busy            = r_busy;
    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_found_port    = r_found_port;
    assign o_aged_count    = r_aged;
    assign o_learn_dropped = r_dropped;
    assign prdata          = (paddr[2] == REG_MAX_AGE) ? {16'd0, r_max_age} : 32'd0;
    assign pready          = 1'b1;

endmodule

// ===== hdl/mlt_checker.sv =====
// Port-level assertions for the MAC learning table, bound to the top level.
module mlt_checker
    import mlt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        i_command,
    input logic              o_done,
    input logic              o_hit,
    input logic [PORT_W-1:0] o_found_port,
    input logic [AGED_W-1:0] o_aged_count,
    input logic              o_learn_dropped
);

    a_tick_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_TICK)) |=>
        (o_done && !busy && !o_hit && (o_aged_count == '0) && !o_learn_dropped))
        else $error("tick result wrong");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_LOOKUP)) |=> (busy && !o_done))
        else $error("lookup did not go busy");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done) == 1'b0 && o_done)
        else $error("busy ended without result");

    a_port_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_found_port == '0))
        else $error("port shown on miss");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $countones({o_hit, (o_aged_count != '0), o_learn_dropped}) <= 1)
        else $error("result mixes kinds");

endmodule

bind mac_learning_table_with_aging_core mlt_checker u_mlt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_command       (i_command),
    .o_done          (o_done),
    .o_hit           (o_hit),
    .o_found_port    (o_found_port),
    .o_aged_count    (o_aged_count),
    .o_learn_dropped (o_learn_dropped)
);

// ===== test/mac_learning_table_with_aging_core_tb.sv =====
// Self-checking testbench for the MAC learning table core: directed and random commands.
`timescale 1ns / 100ps

module mac_learning_table_with_aging_core_tb;
    import mlt_pkg::*;

    localparam int ENTRIES     = DEF_TABLE_ENTRIES;
    localparam int PORTS       = DEF_PORT_COUNT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_SIZE   = 96;
    localparam int FILL_COUNT  = ENTRIES + 2;

    localparam logic [2:0] ADDR_MAX_AGE  = 3'(4 * int'(REG_MAX_AGE));
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic              hit;
        logic [PORT_W-1:0] fport;
        logic [AGED_W-1:0] aged;
        logic              dropped;
    } t_outcome;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [MAC_W-1:0]  i_mac_address;
    logic [PORT_W-1:0] i_port_number;
    logic              o_done;
    logic              o_hit;
    logic [PORT_W-1:0] o_found_port;
    logic [AGED_W-1:0] o_aged_count;
    logic              o_learn_dropped;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // table model
    logic               slot_used  [ENTRIES];
    logic [MAC_W-1:0]   slot_mac   [ENTRIES];
    logic [PORT_W-1:0]  slot_port  [ENTRIES];
    logic [STAMP_W-1:0] slot_stamp [ENTRIES];
    logic [STAMP_W-1:0] seconds;
    logic [AGE_W-1:0]   max_age;

    t_outcome         pending_results [$];
    t_outcome         want_result;
    t_outcome         seen_result;
    logic [MAC_W-1:0] mac_pool [POOL_SIZE];
    int               errors = 0;
    int               cycles = 0;
    bit               idle_on;

    mac_learning_table_with_aging_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_mac_address  (i_mac_address),
        .i_port_number  (i_port_number),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_found_port   (o_found_port),
        .o_aged_count   (o_aged_count),
        .o_learn_dropped(o_learn_dropped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** mac_learning_table_with_aging_core: FAILED **");
            $finish;
        end
    end

    function automatic t_outcome table_step(t_cmd cmd, logic [MAC_W-1:0] mac,
                                            logic [PORT_W-1:0] port);
        t_outcome r;
        int       slot;
        r    = '0;
        slot = -1;
        case (cmd)
            CMD_LEARN: begin
                if (int'(port) < PORTS) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && slot_used[i] && slot_mac[i] == mac) slot = i;
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !slot_used[i]) slot = i;
                    if (slot < 0) begin
                        r.dropped = 1'b1;
                    end else begin
                        slot_used[slot]  = 1'b1;
                        slot_mac[slot]   = mac;
                        slot_port[slot]  = port;
                        slot_stamp[slot] = seconds;
                    end
                end
            end
            CMD_LOOKUP: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!r.hit && slot_used[i] && slot_mac[i] == mac) begin
                        r.hit   = 1'b1;
                        r.fport = slot_port[i];
                    end
                end
            end
            CMD_AGE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_used[i] && (seconds - slot_stamp[i]) > STAMP_W'(max_age)) begin
                        slot_used[i] = 1'b0;
                        if (r.aged != AGED_MAX) r.aged = r.aged + 1'b1;
                    end
                end
            end
            default: seconds = seconds + 1'b1;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen_result = {o_hit, o_found_port, o_aged_count, o_learn_dropped};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat hit=%0d port=%0d aged=%0d dropped=%0d",
                         $time, o_hit, o_found_port, o_aged_count, o_learn_dropped);
                errors++;
            end else begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result) begin
                    $display("%0t: mismatch expected hit=%0d port=%0d aged=%0d dropped=%0d",
                             $time, want_result.hit, want_result.fport, want_result.aged,
                             want_result.dropped);
                    $display("%0t:          actual   hit=%0d port=%0d aged=%0d dropped=%0d",
                             $time, o_hit, o_found_port, o_aged_count, o_learn_dropped);
                    errors++;
                end
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_cmd(t_cmd cmd, logic [MAC_W-1:0] mac, logic [PORT_W-1:0] port);
        bit taken;
        taken = 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            do @(posedge i_clk); while (busy);
            @(negedge i_clk);
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start         = 1'b1;
        i_command     = cmd;
        i_mac_address = mac;
        i_port_number = port;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
                pending_results.push_back(table_step(cmd, mac, port));
            end
            @(negedge i_clk);
        end
        start = 1'b0;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_MAX_AGE && data[AGE_W-1:0] != '0) max_age = data[AGE_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_max_age_reg();
        logic [31:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_MAX_AGE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== {16'b0, max_age}) begin
            $display("%0t: max age readback expected %0d actual %0d", $time, max_age, got);
            errors++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_max_age(logic [AGE_W-1:0] value);
        apb_write(ADDR_MAX_AGE, {16'($urandom), value});
        check_max_age_reg();
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 2) @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        check_max_age_reg();
        send_cmd(CMD_LOOKUP, '0, '0);
        send_cmd(CMD_AGE, '0, '0);
    endtask

    task automatic test_learn_lookup();
        send_cmd(CMD_LEARN, '0, 4'd0);
        send_cmd(CMD_LEARN, '1, 4'd15);
        send_cmd(CMD_LOOKUP, '0, 4'd9);
        send_cmd(CMD_LOOKUP, '1, 4'd0);
        send_cmd(CMD_LEARN, '1, 4'd5);
        send_cmd(CMD_LOOKUP, '1, 4'd0);
        send_cmd(CMD_LOOKUP, 48'h0000_0000_0001, 4'd0);
        send_cmd(CMD_TICK, '1, 4'd15);
    endtask

    task automatic test_register_rules();
        wait_drained();
        apb_write(ADDR_MAX_AGE, 32'h0);
        check_max_age_reg();
        apb_write(ADDR_UNMAPPED, 32'h7);
        check_max_age_reg();
        apb_write(ADDR_MAX_AGE, 32'hFFFF_0000);
        check_max_age_reg();
        set_max_age(16'hFFFF);
        set_max_age(16'd1);
    endtask

    task automatic test_aging();
        send_cmd(CMD_LEARN, 48'h0200_0000_00AA, 4'd3);
        send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_LEARN, 48'h8000_0000_00BB, 4'd4);
        send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_AGE, '0, '0);
        send_cmd(CMD_LOOKUP, 48'h0200_0000_00AA, '0);
        send_cmd(CMD_LOOKUP, 48'h8000_0000_00BB, '0);
        send_cmd(CMD_AGE, '0, '0);
        send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_AGE, '0, '0);
    endtask

    task automatic test_table_full();
        logic [MAC_W-1:0] fresh [FILL_COUNT];
        wait_drained();
        set_max_age(16'hFFFF);
        for (int i = 0; i < FILL_COUNT; i++) begin
            fresh[i] = 48'({$urandom, $urandom});
            send_cmd(CMD_LEARN, fresh[i], 4'($urandom));
        end
        send_cmd(CMD_LEARN, fresh[0], 4'd11);
        send_cmd(CMD_LOOKUP, fresh[0], '0);
        send_cmd(CMD_LOOKUP, fresh[FILL_COUNT-1], '0);
        wait_drained();
        set_max_age(16'd1);
        send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_AGE, '0, '0);
        send_cmd(CMD_LOOKUP, fresh[0], '0);
    endtask

    task automatic run_random(int count);
        t_cmd             cmd;
        logic [MAC_W-1:0] mac;
        int               pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      cmd = CMD_LEARN;
            else if (pick < 70) cmd = CMD_LOOKUP;
            else if (pick < 80) cmd = CMD_AGE;
            else                cmd = CMD_TICK;
            if ($urandom_range(0, 9) == 0) mac = 48'({$urandom, $urandom});
            else                           mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_cmd(cmd, mac, 4'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        // odd entries differ in one bit from the entry before, but for entries 1 and 3
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i % 2 == 1) mac_pool[i] = mac_pool[i-1] ^ (48'd1 << $urandom_range(0, 47));
            else            mac_pool[i] = 48'({$urandom, $urandom});
        end
        mac_pool[0] = '0;
        mac_pool[2] = '1;
        wait_drained();
        set_max_age(16'd1);
        run_random(300);
        wait_drained();
        set_max_age(16'hFFFF);
        run_random(300);
        wait_drained();
        set_max_age(16'd2);
        run_random(300);
        wait_drained();
        set_max_age(16'($urandom_range(3, 20)));
        run_random(300);
        wait_drained();
        set_max_age(16'($urandom_range(2, 10)));
        idle_on = 1'b0;
        run_random(350);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_command     = CMD_LEARN;
        i_mac_address = '0;
        i_port_number = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_on       = 1'b1;
        for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
        seconds = '0;
        max_age = MAX_AGE_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_learn_lookup();
        test_register_rules();
        test_aging();
        test_table_full();
        test_random_traffic();

        wait_drained();
        if (errors == 0) begin
            $display("** mac_learning_table_with_aging_core: PASSED **");
        end else begin
            $display("** mac_learning_table_with_aging_core: FAILED **");
        end
        $finish;
    end

endmodule
